@@ design/shbe_pkg.sv @@
// Shared types and coefficient tables for the spherical-harmonic basis evaluator.
// Used by sh_basis_eval, shbe_datapath and shbe_checker; no dependencies.
package shbe_pkg;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [3:0]         coeff_index;
      logic signed [15:0] coeff_value;
      logic               last;
   } rsp_type;

   // One coefficient slot handed from the issue sequencer to the datapath.
   // x and y are already negated, so all three need 17 bits.
   typedef struct packed {
      logic               valid;
      logic [3:0]         index;
      logic               last;
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
   } issue_type;

   typedef enum logic [1:0] {
      OPND_X,
      OPND_Y,
      OPND_Z,
      OPND_ONE
   } opnd_type;

   // How the two products q1, q2 combine into the quadratic term (ONE = 2^30).
   typedef enum logic [2:0] {
      COMB_Q1,
      COMB_Q1_SUB_Q2,
      COMB_3Q1_SUB_Q2,
      COMB_Q1_SUB_3Q2,
      COMB_3Q1_SUB_ONE,
      COMB_5Q1_SUB_ONE,
      COMB_5Q1_SUB_3ONE
   } comb_type;

   typedef struct packed {
      opnd_type a1;
      opnd_type b1;
      opnd_type a2;
      opnd_type b2;
      comb_type comb;
      opnd_type w;
   } ctrl_type;

   // Every basis value is K * (w * (combination of q1 = a1*b1, q2 = a2*b2)).
   function automatic ctrl_type coeff_ctrl(input logic [3:0] idx);
      ctrl_type c;
      c = '{a1: OPND_ONE, b1: OPND_ONE, a2: OPND_ONE, b2: OPND_ONE,
            comb: COMB_Q1, w: OPND_ONE};
      case (idx)
         4'd0:  c.a1 = OPND_ONE;
         4'd1:  c.a1 = OPND_Y;
         4'd2:  c.a1 = OPND_Z;
         4'd3:  c.a1 = OPND_X;
         4'd4:  begin c.a1 = OPND_X; c.b1 = OPND_Y; end
         4'd5:  begin c.a1 = OPND_Y; c.b1 = OPND_Z; end
         4'd6:  begin c.a1 = OPND_Z; c.b1 = OPND_Z; c.comb = COMB_3Q1_SUB_ONE; end
         4'd7:  begin c.a1 = OPND_X; c.b1 = OPND_Z; end
         4'd8:  begin
            c.a1 = OPND_X; c.b1 = OPND_X; c.a2 = OPND_Y; c.b2 = OPND_Y;
            c.comb = COMB_Q1_SUB_Q2;
         end
         4'd9:  begin
            c.a1 = OPND_X; c.b1 = OPND_X; c.a2 = OPND_Y; c.b2 = OPND_Y;
            c.comb = COMB_3Q1_SUB_Q2; c.w = OPND_Y;
         end
         4'd10: begin c.a1 = OPND_X; c.b1 = OPND_Y; c.w = OPND_Z; end
         4'd11: begin
            c.a1 = OPND_Z; c.b1 = OPND_Z; c.comb = COMB_5Q1_SUB_ONE; c.w = OPND_Y;
         end
         4'd12: begin
            c.a1 = OPND_Z; c.b1 = OPND_Z; c.comb = COMB_5Q1_SUB_3ONE; c.w = OPND_Z;
         end
         4'd13: begin
            c.a1 = OPND_Z; c.b1 = OPND_Z; c.comb = COMB_5Q1_SUB_ONE; c.w = OPND_X;
         end
         4'd14: begin
            c.a1 = OPND_X; c.b1 = OPND_X; c.a2 = OPND_Y; c.b2 = OPND_Y;
            c.comb = COMB_Q1_SUB_Q2; c.w = OPND_Z;
         end
         4'd15: begin
            c.a1 = OPND_X; c.b1 = OPND_X; c.a2 = OPND_Y; c.b2 = OPND_Y;
            c.comb = COMB_Q1_SUB_3Q2; c.w = OPND_X;
         end
         default: c.a1 = OPND_ONE;
      endcase
      return c;
   endfunction

   // Normalization constants, scaled by 2^16.
   function automatic logic [17:0] coeff_k(input logic [3:0] idx);
      logic [17:0] k;
      case (idx)
         4'd0:                     k = 18'd18487;
         4'd1, 4'd2, 4'd3:         k = 18'd32021;
         4'd4, 4'd5, 4'd7:         k = 18'd71601;
         4'd6:                     k = 18'd20670;
         4'd8:                     k = 18'd35801;
         4'd9, 4'd15:              k = 18'd38669;
         4'd10, 4'd14:             k = 18'd189439;
         4'd11, 4'd13:             k = 18'd29953;
         4'd12:                    k = 18'd24456;
         default:                  k = 18'd0;
      endcase
      return k;
   endfunction

endpackage

@@ design/sh_basis_eval.sv @@
// Top level of the spherical-harmonic basis evaluator: band count register,
// coefficient issue sequencer and the shbe_datapath pipeline. Uses shbe_pkg.
//
// Usage:
//  - A request (one direction in req_data, signed Q1.15) is taken at a rising
//    edge with start high and busy low. x and y are negated before evaluation.
//  - The block returns band_count squared coefficients (band_count clamped to
//    1..4), one per cycle in index order, each shown for one cycle with
//    rsp_valid high; the final one carries last.
//  - The first coefficient leaves after the issue register and the six datapath
//    stages; the rest follow in consecutive cycles.
//  - The issue sequencer feeds one coefficient per cycle into the shared six-stage
//    multiply pipeline and takes a new request only once the last coefficient of
//    the current one issues. busy drops on the cycle the last coefficient of a
//    request issues, so results leave with no gaps.
//  - The receiver cannot stall; results are dropped on the floor if ignored.
//  - Reset clears the pipeline and the sequencer and sets band_count to 3. The user
//    writes band_count through csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
module sh_basis_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  shbe_pkg::req_type req_data,
   output logic              rsp_valid,
   output shbe_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_data
);

   logic [2:0]          band_ff;
   shbe_pkg::issue_type iss_ff, iss_in;
   logic [3:0]          last_ix_ff, last_ix_in;
   logic [3:0]          final_ix;
   logic                accept;

   always_comb begin
      case (band_ff)
         3'd0, 3'd1: final_ix = 4'd0;
         3'd2:       final_ix = 4'd3;
         3'd3:       final_ix = 4'd8;
         default:    final_ix = 4'd15;
      endcase
   end

   assign busy   = iss_ff.valid & ~iss_ff.last;
   assign accept = start & ~busy;

   always_comb begin
      iss_in     = iss_ff;
      last_ix_in = last_ix_ff;
      if (accept) begin
         iss_in.valid = 1'b1;
         iss_in.index = 4'd0;
         iss_in.last  = (final_ix == 4'd0);
         iss_in.x     = -$signed({req_data.dir_x[15], req_data.dir_x});
         iss_in.y     = -$signed({req_data.dir_y[15], req_data.dir_y});
         iss_in.z     = $signed({req_data.dir_z[15], req_data.dir_z});
         last_ix_in   = final_ix;
      end else if (busy) begin
         iss_in.index = iss_ff.index + 4'd1;
         iss_in.last  = (iss_ff.index + 4'd1 == last_ix_ff);
      end else begin
         iss_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff    <= 3'd3;
         iss_ff     <= '0;
         last_ix_ff <= 4'd0;
      end else begin
         if (csr_wr_en) begin
            band_ff <= csr_wr_data;
         end
         iss_ff     <= iss_in;
         last_ix_ff <= last_ix_in;
      end
   end

   shbe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .iss       (iss_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/shbe_datapath.sv @@
// Six-stage coefficient pipeline: products, quadratic term, cubic multiply,
// rounding, normalization multiply, rounding and saturation. Uses shbe_pkg.
module shbe_datapath (
   input  logic                clock,
   input  logic                reset,
   input  shbe_pkg::issue_type iss,
   output logic                rsp_valid,
   output shbe_pkg::rsp_type   rsp_data
);

   localparam logic signed [33:0] ONE30 = 34'sd1073741824;

   typedef struct packed {
      logic       valid;
      logic [3:0] index;
      logic       last;
   } tag_type;

   function automatic logic signed [16:0] pick(input shbe_pkg::opnd_type o,
                                               input logic signed [16:0] x,
                                               input logic signed [16:0] y,
                                               input logic signed [16:0] z);
      logic signed [16:0] v;
      case (o)
         shbe_pkg::OPND_X: v = x;
         shbe_pkg::OPND_Y: v = y;
         shbe_pkg::OPND_Z: v = z;
         default:          v = 17'sd32768;
      endcase
      return v;
   endfunction

   shbe_pkg::ctrl_type ctrl0, ctrl1;

   tag_type            t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic signed [31:0] q1_ff, q2_ff;
   logic signed [16:0] w1_ff, w2_ff;
   logic signed [33:0] qt_ff;
   logic signed [50:0] r_ff;
   logic signed [33:0] p_ff;
   logic signed [52:0] m_ff;
   logic               out_valid_ff;
   shbe_pkg::rsp_type  out_ff;

   logic signed [33:0] prod1, prod2;
   logic signed [31:0] q1_in, q2_in;
   logic signed [16:0] w1_in;
   logic signed [33:0] q1e, q2e, qt_in;
   logic signed [50:0] r_in, r_rnd;
   logic signed [33:0] p_in;
   logic signed [18:0] k_s;
   logic signed [52:0] m_in, m_rnd;
   logic signed [19:0] v_rnd;
   shbe_pkg::rsp_type  out_in;

   // Stage 1: two 17x17 products and the cubic operand
   always_comb begin
      ctrl0 = shbe_pkg::coeff_ctrl(iss.index);
      prod1 = pick(ctrl0.a1, iss.x, iss.y, iss.z) * pick(ctrl0.b1, iss.x, iss.y, iss.z);
      prod2 = pick(ctrl0.a2, iss.x, iss.y, iss.z) * pick(ctrl0.b2, iss.x, iss.y, iss.z);
      q1_in = $signed(prod1[31:0]);
      q2_in = $signed(prod2[31:0]);
      w1_in = pick(ctrl0.w, iss.x, iss.y, iss.z);
   end

   // Stage 2: quadratic term at scale 2^30
   always_comb begin
      ctrl1 = shbe_pkg::coeff_ctrl(t1_ff.index);
      q1e   = {{2{q1_ff[31]}}, q1_ff};
      q2e   = {{2{q2_ff[31]}}, q2_ff};
      case (ctrl1.comb)
         shbe_pkg::COMB_Q1:           qt_in = q1e;
         shbe_pkg::COMB_Q1_SUB_Q2:    qt_in = q1e - q2e;
         shbe_pkg::COMB_3Q1_SUB_Q2:   qt_in = (q1e <<< 1) + q1e - q2e;
         shbe_pkg::COMB_Q1_SUB_3Q2:   qt_in = q1e - (q2e <<< 1) - q2e;
         shbe_pkg::COMB_3Q1_SUB_ONE:  qt_in = (q1e <<< 1) + q1e - ONE30;
         shbe_pkg::COMB_5Q1_SUB_ONE:  qt_in = (q1e <<< 2) + q1e - ONE30;
         shbe_pkg::COMB_5Q1_SUB_3ONE: qt_in = (q1e <<< 2) + q1e - (ONE30 <<< 1) - ONE30;
         default:                     qt_in = q1e;
      endcase
   end

   // Stage 3: times w (w = 2^15 leaves quadratic terms unchanged after the shift)
   assign r_in = qt_ff * w2_ff;

   // Stage 4: round by 2^15, ties away from zero
   assign r_rnd = r_ff + 51'sd16384 - {50'd0, r_ff[50]};
   assign p_in  = $signed(r_rnd[48:15]);

   // Stage 5: normalization constant
   assign k_s  = $signed({1'b0, shbe_pkg::coeff_k(t4_ff.index)});
   assign m_in = p_ff * k_s;

   // Stage 6: round by 2^33 and saturate to Q3.13
   always_comb begin
      m_rnd              = m_ff + (53'sd1 <<< 32) - {52'd0, m_ff[52]};
      v_rnd              = $signed(m_rnd[52:33]);
      out_in.coeff_index = t5_ff.index;
      out_in.last        = t5_ff.last;
      if (v_rnd > 20'sd32767) begin
         out_in.coeff_value = 16'sd32767;
      end else if (v_rnd < -20'sd32768) begin
         out_in.coeff_value = -16'sd32768;
      end else begin
         out_in.coeff_value = v_rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff        <= '0;
         t2_ff        <= '0;
         t3_ff        <= '0;
         t4_ff        <= '0;
         t5_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         t1_ff        <= '{valid: iss.valid, index: iss.index, last: iss.last};
         t2_ff        <= t1_ff;
         t3_ff        <= t2_ff;
         t4_ff        <= t3_ff;
         t5_ff        <= t4_ff;
         out_valid_ff <= t5_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      q1_ff  <= q1_in;
      q2_ff  <= q2_in;
      w1_ff  <= w1_in;
      qt_ff  <= qt_in;
      w2_ff  <= w1_ff;
      r_ff   <= r_in;
      p_ff   <= p_in;
      m_ff   <= m_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ design/shbe_checker.sv @@
// Port-level checks for sh_basis_eval, attached by the bind at the end.
// Uses shbe_pkg.
module shbe_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input shbe_pkg::rsp_type rsp_data
);

   // Coefficients of one request leave back to back in index order
   a_index_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=>
         rsp_valid && (rsp_data.coeff_index == $past(rsp_data.coeff_index) + 4'd1))
      else $error("coefficient run broken");

   a_top_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.coeff_index == 4'd15 |-> rsp_data.last)
      else $error("index 15 not marked last");

   // Band zero is a constant
   a_dc_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.coeff_index == 4'd0 |-> rsp_data.coeff_value == 16'sd2311)
      else $error("band zero value wrong");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("not idle after reset");

endmodule

bind sh_basis_eval shbe_checker u_shbe_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sh_basis_eval: directions in, basis coefficients out.
// Depends on shbe_pkg for the request/response structs and on the RTL top only.

module tb_top;

   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     SETTLE_CYCLES = 10;   // pipeline is 7 deep
   localparam longint ONE30         = longint'(1) << 30;

   typedef enum logic [1:0] {
      STEP_REQ,
      STEP_DRAIN,
      STEP_BANDS
   } step_type;

   typedef struct {
      step_type          kind;
      shbe_pkg::req_type dir;
      logic [2:0]        bands;
   } plan_step_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   shbe_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   shbe_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [2:0]        csr_wr_data = 3'd0;

   plan_step_type     plan[$];
   shbe_pkg::rsp_type coeff_queue[$];
   logic [2:0] band_setting = 3'd3;
   int         errors       = 0;
   int         cycles       = 0;
   int         burst_left   = 0;
   int         gap_left     = 0;
   int         quiet_cycles = 0;
   logic       hold;
   logic       nxt_start;
   logic       nxt_wr;

   sh_basis_eval dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint round_shift(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   // normalization factor per basis index, scaled by 2^16
   function automatic longint norm_factor(int idx);
      case (idx)
         0:               return 18487;
         1, 2, 3:         return 32021;
         4, 5, 7:         return 71601;
         6:               return 20670;
         8:               return 35801;
         9, 15:           return 38669;
         10, 14:          return 189439;
         11, 13:          return 29953;
         default:         return 24456;
      endcase
   endfunction

   function automatic logic signed [15:0] to_q313(longint k, longint p);
      longint r;
      r = round_shift(k * p, 33);
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic void eval_basis(shbe_pkg::req_type d, logic [2:0] bands);
      longint            x, y, z, xx, yy, zz;
      longint            poly [16];
      int                n;
      int                i;
      shbe_pkg::rsp_type c;
      n = (bands == 3'd0) ? 1 : (bands > 3'd4) ? 4 : int'(bands);
      x = -longint'($signed(d.dir_x));   // -(-1.0) stays +1.0 at this width
      y = -longint'($signed(d.dir_y));
      z = longint'($signed(d.dir_z));
      xx = x * x;
      yy = y * y;
      zz = z * z;
      poly[0]  = ONE30;
      poly[1]  = y * 32768;
      poly[2]  = z * 32768;
      poly[3]  = x * 32768;
      poly[4]  = x * y;
      poly[5]  = y * z;
      poly[6]  = 3 * zz - ONE30;
      poly[7]  = x * z;
      poly[8]  = xx - yy;
      // cubic terms come in at 2^45, bring to 2^30
      poly[9]  = round_shift(3 * xx * y - yy * y, 15);
      poly[10] = round_shift(x * y * z, 15);
      poly[11] = round_shift(5 * zz * y - y * ONE30, 15);
      poly[12] = round_shift(5 * zz * z - 3 * z * ONE30, 15);
      poly[13] = round_shift(5 * zz * x - x * ONE30, 15);
      poly[14] = round_shift(xx * z - yy * z, 15);
      poly[15] = round_shift(xx * x - 3 * yy * x, 15);
      for (i = 0; i < n * n; i++) begin
         c.coeff_index = 4'(i);
         c.coeff_value = to_q313(norm_factor(i), poly[i]);
         c.last        = (i == n * n - 1);
         coeff_queue.push_back(c);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [15:0] edge_value();
      case ($urandom_range(0, 6))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         3:       return 16'sh0001;
         4:       return 16'shffff;
         5:       return 16'sh8001;
         default: return 16'sh4000;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_component(int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return edge_value();
         default: return 16'($signed($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   function automatic shbe_pkg::req_type rand_dir();
      shbe_pkg::req_type d;
      int                sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         d.dir_x = 16'($urandom);
         d.dir_y = 16'($urandom);
         d.dir_z = 16'($urandom);
      end else if (sel < 7) begin
         d.dir_x = edge_value();
         d.dir_y = edge_value();
         d.dir_z = edge_value();
      end else begin
         d.dir_x = rand_component($urandom_range(0, 2));
         d.dir_y = rand_component($urandom_range(0, 2));
         d.dir_z = rand_component($urandom_range(0, 2));
      end
      return d;
   endfunction

   task automatic add_request(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      plan_step_type s;
      s.kind  = STEP_REQ;
      s.dir   = '{dir_x: x, dir_y: y, dir_z: z};
      s.bands = 3'd0;
      plan.push_back(s);
   endtask

   // band changes only once everything in flight has drained
   task automatic add_bands(logic [2:0] bands);
      plan_step_type s;
      s.dir   = '0;
      s.bands = bands;
      s.kind  = STEP_DRAIN;
      plan.push_back(s);
      s.kind  = STEP_BANDS;
      plan.push_back(s);
   endtask

   task automatic add_random(int count);
      shbe_pkg::req_type d;
      int                i;
      for (i = 0; i < count; i++) begin
         d = rand_dir();
         add_request(d.dir_x, d.dir_y, d.dir_z);
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         start        <= 1'b0;
         csr_wr_en    <= 1'b0;
         band_setting  = 3'd3;
         quiet_cycles  = 0;
         gap_left      = 0;
         burst_left    = 0;
      end else begin
         hold = start && busy;
         if (start && !busy)
            eval_basis(req_data, band_setting);
         if (csr_wr_en)
            band_setting = csr_wr_data;
         quiet_cycles = (coeff_queue.size() == 0 && !busy && !start) ? quiet_cycles + 1 : 0;
         nxt_start = hold;
         nxt_wr    = 1'b0;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (plan.size() > 0) begin
               case (plan[0].kind)
                  STEP_REQ: begin
                     req_data  <= plan[0].dir;
                     nxt_start  = 1'b1;
                     void'(plan.pop_front());
                     if (burst_left > 0) begin
                        burst_left--;
                     end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                     end
                  end
                  STEP_DRAIN: begin
                     if (quiet_cycles >= SETTLE_CYCLES)
                        void'(plan.pop_front());
                  end
                  default: begin
                     csr_wr_data <= plan[0].bands;
                     nxt_wr       = 1'b1;
                     void'(plan.pop_front());
                  end
               endcase
            end
         end
         start     <= nxt_start;
         csr_wr_en <= nxt_wr;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      shbe_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (coeff_queue.size() == 0) begin
            report("unrequested coefficient index", rsp_data.coeff_index, -1);
         end else begin
            want = coeff_queue.pop_front();
            if (rsp_data.coeff_index !== want.coeff_index)
               report("coeff_index", rsp_data.coeff_index, want.coeff_index);
            if (rsp_data.coeff_value !== want.coeff_value)
               report($sformatf("coeff_value[%0d]", want.coeff_index),
                      $signed(rsp_data.coeff_value), $signed(want.coeff_value));
            if (rsp_data.last !== want.last)
               report($sformatf("last[%0d]", want.coeff_index), rsp_data.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // reset band count of 3
      add_request(16'sh0000, 16'sh0000, 16'sh7fff);
      add_request(16'sh8000, 16'sh8000, 16'sh8000);
      add_request(16'sh5a82, 16'sha57e, 16'sh0000);

      // all sixteen coefficients on axes, corners, full-scale edges and diagonals, then random directions
      add_bands(3'd4);
      add_request(16'sh0000, 16'sh0000, 16'sh0000);
      add_request(16'sh8000, 16'sh8000, 16'sh8000);
      add_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
      add_request(16'sh8000, 16'sh0000, 16'sh0000);
      add_request(16'sh0000, 16'sh8000, 16'sh0000);
      add_request(16'sh0000, 16'sh0000, 16'sh8000);
      add_request(16'sh7fff, 16'sh0000, 16'sh0000);
      add_request(16'sh0000, 16'sh7fff, 16'sh0000);
      add_request(16'sh0000, 16'sh0000, 16'sh7fff);
      add_request(16'sh0001, 16'shffff, 16'sh0001);
      add_request(16'shffff, 16'sh0001, 16'shffff);
      add_request(16'sh5a82, 16'sh5a82, 16'sh0000);
      add_request(16'sh49e7, 16'sh49e7, 16'sh49e7);
      add_request(16'sh8000, 16'sh7fff, 16'sh8000);
      add_request(16'sh7fff, 16'sh8000, 16'sh7fff);
      add_request(16'sh4000, 16'sh9126, 16'sh0000);
      add_random(80);

      // zero clamps to one band, anything above four clamps to four
      add_bands(3'd7);
      add_random(40);
      add_bands(3'd0);
      add_random(30);
      add_bands(3'd1);
      add_random(30);
      add_bands(3'd5);
      add_random(20);
      add_bands(3'd2);
      add_random(30);
      add_bands(3'd6);
      add_random(20);
      add_bands(3'd3);
      add_random(40);
      add_bands(3'd4);
      add_random(20);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sampled mid-cycle so the driver's updates at the edge have settled
      while (plan.size() != 0 || start || coeff_queue.size() != 0)
         @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      if (errors == 0 && coeff_queue.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
design/shbe_pkg.sv
design/shbe_datapath.sv
design/sh_basis_eval.sv
design/shbe_checker.sv
verif/tb_top.sv
